>>> rtl/core/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg: shared definitions for the process handle table
// Field widths, operation and status codes, item structs and the control
// and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pht_pkg;

  localparam int HANDLE_W = 32;
  localparam int SLOT_W   = 10;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam int DEF_LOG2_SLOTS = 10;
  localparam int DEF_SLOTS      = 1024;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;
  localparam logic [OP_W-1:0] OP_SET_CUR = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [HANDLE_W-1:0] handle_in;
    logic [HANDLE_W-1:0] parent_handle;
    logic [SLOT_W-1:0]   slot_in;
    logic                check_perm;
  } pht_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HANDLE_W-1:0] handle_out;
    logic [SLOT_W-1:0]   slot_out;
    logic                slot_present;
  } pht_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic accept;
    logic exec;
  } pht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
  } pht_stat_t;

endpackage

>>> rtl/core/pht_ctrl.sv
// ----------------------------------------------------------------------------
// pht_ctrl: sequencing controller for the process handle table
// Runs the clearing pass after reset, then takes one item at a time: the
// memories are read as it is accepted, then the execute state follows.
// ----------------------------------------------------------------------------
module pht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output pht_pkg::pht_cmd_t   cmd,
  input  pht_pkg::pht_stat_t  stat
);
  import pht_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign cmd.clr_en = (state_r == S_CLEAR);
  assign cmd.accept = (state_r == S_IDLE) && start;
  assign cmd.exec   = (state_r == S_EXEC);

  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_IDLE)
    else $error("execute state lasted more than one cycle");

  a_clear_ends_at_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_CLEAR && state_r != S_CLEAR) |-> $past(stat.clr_last))
    else $error("clearing pass left before its last entry");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && cmd.exec))
    else $error("accepted item did not enter execution");

endmodule

>>> rtl/core/pht_datapath.sv
// ----------------------------------------------------------------------------
// pht_datapath: slot memories, free stack and result register
// Holds the busy, handle and parent stores, the free stack, the counters and
// the current slot, and works out each operation's result.
// ----------------------------------------------------------------------------
module pht_datapath #(
  parameter int LOG2_SLOTS = pht_pkg::DEF_LOG2_SLOTS,
  parameter int SLOTS      = pht_pkg::DEF_SLOTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pht_pkg::pht_cmd_t   cmd,
  output pht_pkg::pht_stat_t  stat,
  input  pht_pkg::pht_in_t    in_data,
  output logic                out_strobe,
  output pht_pkg::pht_out_t   out_data
);
  import pht_pkg::*;

  localparam int IDX_W = LOG2_SLOTS;
  localparam int CNT_W = LOG2_SLOTS + 1;
  localparam int GEN_W = HANDLE_W - LOG2_SLOTS - 1;

  // Memories.
  logic                busy_mem   [SLOTS];
  logic [IDX_W-1:0]    stack_mem  [SLOTS];
  logic [HANDLE_W-1:0] handle_mem [SLOTS];
  logic [HANDLE_W-1:0] parent_mem [SLOTS];

  // Control state.
  logic [CNT_W-1:0]    fc_r, fc_nxt;
  logic [GEN_W-1:0]    gen_r, gen_nxt;
  logic [IDX_W-1:0]    cur_slot_r, cur_slot_nxt;
  logic                cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                out_strobe_r;

  // Payload registers.
  logic [HANDLE_W-1:0] cur_handle_r, cur_handle_nxt;
  pht_in_t             req_r;
  logic [IDX_W-1:0]    req_idx_r;
  logic                req_oor_r;
  logic                busy_rd_r;
  logic [IDX_W-1:0]    stack_rd_r;
  logic [HANDLE_W-1:0] handle_rd_r;
  logic [HANDLE_W-1:0] parent_rd_r;
  pht_out_t            out_data_r;

  // Read side.
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_oor;
  logic [CNT_W-1:0]    fc_m1;

  // Write side and result.
  logic                busy_we, busy_wdata;
  logic [IDX_W-1:0]    busy_waddr;
  logic                stack_we;
  logic [IDX_W-1:0]    stack_waddr, stack_wdata;
  logic                hp_we;
  logic [IDX_W-1:0]    hp_waddr;
  logic [HANDLE_W-1:0] handle_wdata, parent_wdata;
  logic [GEN_W-1:0]    gen_inc;
  logic [HANDLE_W-1:0] new_handle;
  logic                perm_ok;
  pht_out_t            res;

  assign fc_m1   = fc_r - CNT_W'(1);
  assign rd_oor  = (32'(in_data.slot_in) >= 32'(SLOTS));
  assign rd_idx  = (in_data.op == OP_LOOKUP) ? in_data.handle_in[IDX_W-1:0]
                                             : IDX_W'(in_data.slot_in);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r     <= in_data;
      req_idx_r <= rd_idx;
      req_oor_r <= rd_oor;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_we) busy_mem[busy_waddr] <= busy_wdata;
    if (cmd.accept) busy_rd_r <= busy_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (cmd.accept) stack_rd_r <= stack_mem[fc_m1[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (hp_we) begin
      handle_mem[hp_waddr] <= handle_wdata;
      parent_mem[hp_waddr] <= parent_wdata;
    end
    if (cmd.accept) begin
      handle_rd_r <= handle_mem[rd_idx];
      parent_rd_r <= parent_mem[rd_idx];
    end
  end

  assign gen_inc    = gen_r + GEN_W'(1);
  assign new_handle = {gen_inc, 1'b0, stack_rd_r};
  assign perm_ok    = cur_valid_r &&
                      ((req_idx_r == cur_slot_r) || (parent_rd_r == cur_handle_r));

  always_comb begin
    busy_we        = 1'b0;
    busy_waddr     = req_idx_r;
    busy_wdata     = 1'b0;
    stack_we       = 1'b0;
    stack_waddr    = fc_r[IDX_W-1:0];
    stack_wdata    = req_idx_r;
    hp_we          = 1'b0;
    hp_waddr       = stack_rd_r;
    handle_wdata   = new_handle;
    parent_wdata   = req_r.parent_handle;
    fc_nxt         = fc_r;
    gen_nxt        = gen_r;
    cur_slot_nxt   = cur_slot_r;
    cur_valid_nxt  = cur_valid_r;
    cur_handle_nxt = cur_handle_r;
    clr_cnt_nxt    = clr_cnt_r;
    res            = '0;
    res.status     = STAT_BAD;

    if (cmd.clr_en) begin
      // Every slot free, and the stack holds the indices with slot zero on top.
      busy_we     = 1'b1;
      busy_waddr  = clr_cnt_r;
      stack_we    = 1'b1;
      stack_waddr = clr_cnt_r;
      stack_wdata = IDX_W'(SLOTS - 1) - clr_cnt_r;
      clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
    end else if (cmd.exec) begin
      case (req_r.op)
        OP_ALLOC: begin
          if (fc_r == '0) begin
            res.status = STAT_FULL;
          end else begin
            fc_nxt           = fc_m1;
            gen_nxt          = gen_inc;
            busy_we          = 1'b1;
            busy_waddr       = stack_rd_r;
            busy_wdata       = 1'b1;
            hp_we            = 1'b1;
            res.status       = STAT_OK;
            res.handle_out   = new_handle;
            res.slot_out     = SLOT_W'(stack_rd_r);
            res.slot_present = 1'b1;
          end
        end
        OP_FREE: begin
          if (!req_oor_r && busy_rd_r) begin
            busy_we = 1'b1;
            if (fc_r < CNT_W'(SLOTS)) begin
              stack_we = 1'b1;
              fc_nxt   = fc_r + CNT_W'(1);
            end
            if (cur_valid_r && (cur_slot_r == req_idx_r)) cur_valid_nxt = 1'b0;
            res.status       = STAT_OK;
            res.handle_out   = handle_rd_r;
            res.slot_out     = SLOT_W'(req_idx_r);
            res.slot_present = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (req_r.handle_in == '0) begin
            res.status = STAT_OK;
            if (cur_valid_r) begin
              res.handle_out   = cur_handle_r;
              res.slot_out     = SLOT_W'(cur_slot_r);
              res.slot_present = 1'b1;
            end
          end else if (busy_rd_r && (handle_rd_r == req_r.handle_in) &&
                       (!req_r.check_perm || perm_ok)) begin
            res.status       = STAT_OK;
            res.handle_out   = handle_rd_r;
            res.slot_out     = SLOT_W'(req_idx_r);
            res.slot_present = 1'b1;
          end
        end
        OP_SET_CUR: begin
          if (!req_oor_r && busy_rd_r) begin
            cur_slot_nxt     = req_idx_r;
            cur_valid_nxt    = 1'b1;
            cur_handle_nxt   = handle_rd_r;
            res.status       = STAT_OK;
            res.handle_out   = handle_rd_r;
            res.slot_out     = SLOT_W'(req_idx_r);
            res.slot_present = 1'b1;
          end
        end
        default: begin
          res.status = STAT_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r         <= CNT_W'(SLOTS);
      gen_r        <= '0;
      cur_slot_r   <= '0;
      cur_valid_r  <= 1'b0;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      fc_r         <= fc_nxt;
      gen_r        <= gen_nxt;
      cur_slot_r   <= cur_slot_nxt;
      cur_valid_r  <= cur_valid_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_strobe_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    cur_handle_r <= cur_handle_nxt;
    if (cmd.exec) out_data_r <= res;
  end

  assign stat.clr_last = (clr_cnt_r == IDX_W'(SLOTS - 1));
  assign out_strobe    = out_strobe_r;
  assign out_data      = out_data_r;

  a_full_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.status == STAT_FULL) |-> (fc_r == '0))
    else $error("no-free-slot result while the free stack holds entries");

  a_error_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_data_r.status != STAT_OK) |->
      (out_data_r.handle_out == '0 && !out_data_r.slot_present))
    else $error("error result carries a handle or slot");

endmodule

>>> rtl/core/process_handle_table.sv
// ----------------------------------------------------------------------------
// process_handle_table: generational process handle table
// Process slots with a last-in-first-out free stack, generation-tagged
// handles, a stored parent handle per slot and a current-slot register.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all SLOTS slots, one slot a
// cycle, marking every slot free and loading the free stack with slot zero
// on top; busy stays high throughout. From then on an item is taken at a
// rising edge where start is high and busy is low: the slot memories and
// the free stack are read as it is accepted, and the execute state writes
// them back and registers the result. Because of that read-modify-write over
// the synchronous slot memories, busy stays high in the execute state and no
// new item is accepted until the last one has been executed. The result is
// shown on out_data for exactly one cycle with out_strobe high, and the
// receiver cannot hold it off; busy is already low in that cycle, so the
// next item may be started while the result is on the ports.
module process_handle_table #(
  parameter int LOG2_SLOTS = pht_pkg::DEF_LOG2_SLOTS,
  parameter int SLOTS      = pht_pkg::DEF_SLOTS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pht_pkg::pht_in_t  in_data,
  output logic              out_strobe,
  output pht_pkg::pht_out_t out_data
);
  import pht_pkg::*;

  // The controller only sequences; all storage and decisions sit in the
  // datapath, which it drives through the command group.
  pht_cmd_t  cmd;
  pht_stat_t stat;

  pht_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  // Handles are formed as the incremented generation above a zero bit and
  // the slot index, so a stale handle to a reused slot no longer matches.
  pht_datapath #(
    .LOG2_SLOTS (LOG2_SLOTS),
    .SLOTS      (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule
